// ----- design/assert_macros.svh -----
// Assertion shorthands for the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/ccsm_pkg.sv -----
package ccsm_pkg;

  localparam int MAX_CLIENTS      = 16;
  localparam int SLOTS_PER_CLIENT = 16;

  localparam int BADGE_W = 32;
  localparam int CAP_W   = 32;
  localparam int SLOT_W  = 4;
  localparam int STATUS_W = 2;

  localparam int ENTRY_W   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int COUNT_W   = $clog2(SLOTS_PER_CLIENT + 1);
  localparam int SIDX_W    = (SLOTS_PER_CLIENT > 1) ? $clog2(SLOTS_PER_CLIENT) : 1;
  localparam int RAM_AW    = ENTRY_W + SIDX_W;
  localparam int RAM_DEPTH = 1 << RAM_AW;

  localparam logic MODE_SET = 1'b0;
  localparam logic MODE_GET = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_FULL,
    ST_NO_ENTRY
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_READ,
    S_CMP,
    S_MISS,
    S_RESULT
  } state_t;

  typedef logic [ENTRY_W-1:0] entry_idx_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [BADGE_W-1:0] badge_t;

  // Priority information rippled along the row of client cells.
  typedef struct packed {
    logic       hit;
    entry_idx_t hit_idx;
    count_t     hit_count;
    logic       free;
    entry_idx_t free_idx;
  } chain_t;

  // Update command broadcast to the row; only the selected cell acts on it.
  typedef struct packed {
    logic       claim;
    logic       bump;
    entry_idx_t sel;
    badge_t     badge;
  } cell_cmd_t;

  // Low bits of a slot index as shown on the result channel.
  function automatic logic [SLOT_W-1:0] to_slot(input count_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[SLOT_W-1:0];
  endfunction

endpackage

// ----- design/ccsm_if.sv -----
interface ccsm_req_if;
  import ccsm_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [BADGE_W-1:0] client_id;
  logic [CAP_W-1:0]   capability;

  modport source (output valid, mode, client_id, capability, input ready);
  modport sink   (input valid, mode, client_id, capability, output ready);
endinterface

interface ccsm_rsp_if;
  import ccsm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic [STATUS_W-1:0] status;

  modport source (output valid, slot, status, input ready);
  modport sink   (input valid, slot, status, output ready);
endinterface

// ----- design/ccsm_ram.sv -----
module ccsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/ccsm_cell.sv -----
module ccsm_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  ccsm_pkg::entry_idx_t idx,
  input  ccsm_pkg::badge_t     req_badge,
  input  ccsm_pkg::cell_cmd_t  cmd,
  input  ccsm_pkg::chain_t     chain_in,
  output ccsm_pkg::chain_t     chain_out
);
  import ccsm_pkg::*;

  logic   used;
  badge_t badge;
  count_t count;
  logic   hit_here;
  logic   mine;

  assign hit_here = used && (badge == req_badge);
  assign mine     = (cmd.sel == idx);

  // An earlier cell in the row always wins, so the lowest index is reported.
  always_comb begin
    chain_out.hit       = chain_in.hit || hit_here;
    chain_out.hit_idx   = chain_in.hit ? chain_in.hit_idx : idx;
    chain_out.hit_count = chain_in.hit ? chain_in.hit_count : count;
    chain_out.free      = chain_in.free || !used;
    chain_out.free_idx  = chain_in.free ? chain_in.free_idx : idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= 1'b0;
      count <= '0;
    end else if (mine && cmd.claim) begin
      used  <= 1'b1;
      count <= '0;
    end else if (mine && cmd.bump) begin
      count <= count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mine && cmd.claim) begin
      badge <= cmd.badge;
    end
  end

endmodule

// ----- design/client_cap_slot_map_unit.sv -----
// Client capability slot map.
// Requests arrive on req (mode, client_id, capability) and each one produces
// exactly one result on rsp (slot, status). Both channels use valid/ready and
// a transfer happens when both are high at a rising edge of clk.
// One request is processed at a time. After the request transfer the row of
// client cells resolves the badge in the lookup state, then the client's
// filled slots are read from the slot RAM one by one, each in a read state
// and a compare state. A hit goes straight to the result state; otherwise a
// miss state appends the capability or reports a miss or a full client, then
// the result state loads the result register. Requests that fail at the badge
// lookup go from the lookup state straight to the result state. The slot scan
// goes through the single RAM read port.
// The result register holds its value while rsp.ready is low; the next request
// is taken only after the result has been loaded, so a stalled receiver holds
// off at most one further request in the sequencer.
// Synchronous reset marks every client entry free with no filled slots; the
// slot RAM is not cleared, as only filled slots are ever read.
module client_cap_slot_map_unit (
  input logic         clk,
  input logic         rst,
  ccsm_req_if.sink    req,
  ccsm_rsp_if.source  rsp
);
  import ccsm_pkg::*;

  state_t            state, state_next;
  logic              req_mode, req_mode_next;
  badge_t            req_badge, req_badge_next;
  logic [CAP_W-1:0]  req_cap, req_cap_next;
  entry_idx_t        entry, entry_next;
  count_t            fill, fill_next;
  count_t            scan, scan_next;
  logic [SLOT_W-1:0] res_slot, res_slot_next;
  status_t           res_status, res_status_next;

  logic              out_valid;
  logic [SLOT_W-1:0] out_slot;
  status_t           out_status;
  logic              out_load;

  cell_cmd_t         cmd;
  chain_t            chain [MAX_CLIENTS+1];
  count_t            scan_inc;

  logic              ram_we;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_waddr;
  logic [RAM_AW-1:0] ram_raddr;
  logic [CAP_W-1:0]  ram_rdata;

  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_CLIENTS; g++) begin : g_cell
    ccsm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (ENTRY_W'(g)),
      .req_badge (req_badge),
      .cmd       (cmd),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  ccsm_ram #(
    .WIDTH (CAP_W),
    .DEPTH (RAM_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_cap),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign scan_inc  = scan + COUNT_W'(1);
  assign ram_raddr = {entry, scan[SIDX_W-1:0]};
  assign ram_waddr = {entry, fill[SIDX_W-1:0]};

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.slot   = out_slot;
  assign rsp.status = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    req_mode_next   = req_mode;
    req_badge_next  = req_badge;
    req_cap_next    = req_cap;
    entry_next      = entry;
    fill_next       = fill;
    scan_next       = scan;
    res_slot_next   = res_slot;
    res_status_next = res_status;
    cmd             = '0;
    cmd.badge       = req_badge;
    cmd.sel         = entry;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    out_load        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          req_mode_next  = req.mode;
          req_badge_next = req.client_id;
          req_cap_next   = req.capability;
          state_next     = S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        scan_next       = '0;
        res_slot_next   = '0;
        res_status_next = ST_OK;
        if (chain[MAX_CLIENTS].hit) begin
          entry_next = chain[MAX_CLIENTS].hit_idx;
          fill_next  = chain[MAX_CLIENTS].hit_count;
          state_next = (chain[MAX_CLIENTS].hit_count == '0) ? S_MISS : S_READ;
        end else if (req_mode == MODE_GET) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_RESULT;
        end else if (chain[MAX_CLIENTS].free) begin
          cmd.claim  = 1'b1;
          cmd.sel    = chain[MAX_CLIENTS].free_idx;
          entry_next = chain[MAX_CLIENTS].free_idx;
          fill_next  = '0;
          state_next = S_MISS;
        end else begin
          res_status_next = ST_NO_ENTRY;
          state_next      = S_RESULT;
        end
      end

      S_READ: begin
        ram_re     = 1'b1;
        state_next = S_CMP;
      end

      S_CMP: begin
        if (ram_rdata == req_cap) begin
          res_slot_next = to_slot(scan);
          state_next    = S_RESULT;
        end else if (scan_inc == fill) begin
          state_next = S_MISS;
        end else begin
          scan_next  = scan_inc;
          state_next = S_READ;
        end
      end

      S_MISS: begin
        state_next = S_RESULT;
        if (req_mode == MODE_GET) begin
          res_status_next = ST_NOT_FOUND;
        end else if (fill >= COUNT_W'(SLOTS_PER_CLIENT)) begin
          res_status_next = ST_FULL;
        end else begin
          ram_we        = 1'b1;
          cmd.bump      = 1'b1;
          res_slot_next = to_slot(fill);
        end
      end

      S_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_mode   <= req_mode_next;
    req_badge  <= req_badge_next;
    req_cap    <= req_cap_next;
    entry      <= entry_next;
    fill       <= fill_next;
    scan       <= scan_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot   <= res_slot;
      out_status <= res_status;
    end
  end

endmodule

// ----- design/ccsm_checker.sv -----
`include "assert_macros.svh"

module ccsm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [ccsm_pkg::SLOT_W-1:0]   rsp_slot,
  input logic [ccsm_pkg::STATUS_W-1:0] rsp_status
);
  import ccsm_pkg::*;

  logic       req_xfer;
  logic       rsp_xfer;
  logic [1:0] pending;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  // Counts requests whose result has not been transferred yet; one result can
  // wait in the output register while the next request is in the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (req_xfer && !rsp_xfer) begin
      pending <= pending + 2'd1;
    end else if (rsp_xfer && !req_xfer) begin
      pending <= pending - 2'd1;
    end
  end

  `ASSERT_SAME(a_result_has_request, rsp_valid, pending != 2'd0)
  `ASSERT_SAME(a_error_slot_zero, rsp_valid && (rsp_status != ST_OK), rsp_slot == '0)
  `ASSERT_NEXT(a_one_at_a_time, req_xfer, !req_ready)
  `ASSERT_NEXT(a_result_held, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind client_cap_slot_map_unit ccsm_checker u_ccsm_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_slot   (rsp.slot),
  .rsp_status (rsp.status)
);
